// ===== hdl/acs_pkg.sv =====
// acs_pkg: widths, constants and types shared by the analog channel scaler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package acs_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int VALUE_W    = 16;
    localparam int QTY_W      = 2;
    localparam int DIVIDEND_W = 19;
    localparam int DIVISOR_W  = SAMPLE_W;
    localparam int MULT_W     = 7;

    localparam logic [QTY_W-1:0] PHASE_CHIP = 2'd0;
    localparam logic [QTY_W-1:0] PHASE_VOLT = 2'd1;
    localparam logic [QTY_W-1:0] PHASE_AIR  = 2'd2;

    localparam logic [MULT_W-1:0]    CHIP_MUL   = 7'd28;
    localparam logic [DIVISOR_W-1:0] CHIP_DIV   = 12'd75;
    localparam logic [VALUE_W-1:0]   CHIP_OFS   = 16'd456;
    localparam logic [SAMPLE_W-1:0]  CHIP_LIMIT = 12'd2000;
    localparam logic [MULT_W-1:0]    VOLT_MUL   = 7'd7;
    localparam logic [DIVISOR_W-1:0] VOLT_DIV   = 12'd59;
    localparam logic [MULT_W-1:0]    AIR_MUL    = 7'd91;
    localparam logic [VALUE_W-1:0]   AIR_OFS    = 16'd168;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_HOLD
    } acs_state_t;

endpackage

`default_nettype wire

// ===== hdl/acs_if.sv =====
// acs_if: valid/ready channels for the sample word and the result word.
// Depends on acs_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface acs_sample_if
    import acs_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink   (input valid, input adc_sample, output ready);
endinterface

interface acs_result_if
    import acs_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [QTY_W-1:0]   quantity;
    logic [VALUE_W-1:0] scaled_value;
    logic               divide_fault;
    logic [QTY_W-1:0]   next_channel;

    modport source (output valid, output quantity, output scaled_value,
                    output divide_fault, output next_channel, input ready);
    modport sink   (input valid, input quantity, input scaled_value,
                    input divide_fault, input next_channel, output ready);
endinterface

`default_nettype wire

// ===== hdl/acs_serial_div.sv =====
// acs_serial_div: restoring divider, one quotient bit per cycle.
// Depends on acs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module acs_serial_div
    import acs_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       done,
    output logic [DIVIDEND_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DIVIDEND_W - 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dsr_reg;

    logic [DIVISOR_W:0]    trial;
    logic                  fits;
    logic [DIVISOR_W:0]    diff;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVIDEND_W-1:0] quo_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIVIDEND_W-1]};
        fits     = trial >= {1'b0, dsr_reg};
        diff     = trial - {1'b0, dsr_reg};
        rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== hdl/analog_channel_scaler_top.sv =====
// Analog channel scaler: chip temperature, supply voltage, air temperature.
// Each accepted sample runs through 19 divider steps, then the output register.
// A new sample is taken only after the previous result has moved into the output register.
// A finished result waits in the output register while the next word runs.
// Reset (rst_n, async low): phase back to chip temperature, saved sample 0.
// Depends on acs_pkg, acs_if, acs_serial_div.
`timescale 1ns / 1ps
`default_nettype none

module analog_channel_scaler_top
    import acs_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    acs_sample_if.sink  sample,
    acs_result_if.source result
);

    acs_state_t            state_reg, state_next;
    logic [QTY_W-1:0]      phase_reg;
    logic [SAMPLE_W-1:0]   saved_reg;
    logic [SAMPLE_W-1:0]   x_reg;
    logic [QTY_W-1:0]      qty_reg;
    logic                  fault_reg;

    logic                  out_valid_reg;
    logic [QTY_W-1:0]      out_qty_reg;
    logic [VALUE_W-1:0]    out_value_reg;
    logic                  out_fault_reg;
    logic [QTY_W-1:0]      out_next_reg;

    logic                  div_start;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
    logic [MULT_W-1:0]     mul_k;
    logic [DIVIDEND_W-1:0] quotient;
    logic [VALUE_W-1:0]    q16;
    logic [VALUE_W-1:0]    value;
    logic [QTY_W-1:0]      next_phase;
    logic                  accept;
    logic                  load_out;
    logic                  out_free;

    assign accept   = sample.valid && sample.ready;
    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        mul_k   = CHIP_MUL;
        divisor = CHIP_DIV;
        unique case (phase_reg)
            PHASE_CHIP:
            begin
                mul_k   = CHIP_MUL;
                divisor = CHIP_DIV;
            end
            PHASE_VOLT:
            begin
                mul_k   = VOLT_MUL;
                divisor = VOLT_DIV;
            end
            PHASE_AIR:
            begin
                mul_k   = AIR_MUL;
                divisor = saved_reg;
            end
            default:
            begin
                mul_k   = CHIP_MUL;
                divisor = CHIP_DIV;
            end
        endcase
        dividend  = DIVIDEND_W'(sample.adc_sample) * DIVIDEND_W'(mul_k);
        div_start = accept && (phase_reg inside {PHASE_CHIP, PHASE_VOLT, PHASE_AIR});
    end

    acs_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        q16 = quotient[VALUE_W-1:0];
        unique case (qty_reg)
            PHASE_CHIP: value = (x_reg < CHIP_LIMIT) ? q16 - CHIP_OFS : '0;
            PHASE_VOLT: value = q16;
            PHASE_AIR:  value = fault_reg ? AIR_OFS : AIR_OFS - q16;
            default:    value = '0;
        endcase
        unique case (qty_reg)
            PHASE_CHIP: next_phase = PHASE_VOLT;
            PHASE_VOLT: next_phase = PHASE_AIR;
            default:    next_phase = PHASE_CHIP;
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        load_out     = 1'b0;
        sample.ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                sample.ready = 1'b1;
                if (div_start)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (out_free)
                    begin
                        load_out   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                        state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PHASE_CHIP;
            saved_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                unique case (phase_reg)
                    PHASE_CHIP: phase_reg <= PHASE_VOLT;
                    PHASE_VOLT:
                    begin
                        phase_reg <= PHASE_AIR;
                        saved_reg <= sample.adc_sample;
                    end
                    default:    phase_reg <= PHASE_CHIP;
                endcase
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            x_reg     <= sample.adc_sample;
            qty_reg   <= phase_reg;
            fault_reg <= (phase_reg == PHASE_AIR) && (saved_reg == '0);
        end
        if (load_out)
        begin
            out_qty_reg   <= qty_reg;
            out_value_reg <= value;
            out_fault_reg <= fault_reg;
            out_next_reg  <= next_phase;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.quantity     = out_qty_reg;
    assign result.scaled_value = out_value_reg;
    assign result.divide_fault = out_fault_reg;
    assign result.next_channel = out_next_reg;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking bench for analog_channel_scaler_top, driving sample words and checking
// each result word against a cycle-free predictor of the three-channel scaling.
// Depends on acs_pkg, acs_if and the RTL of the analog channel scaler.
`timescale 1ns / 1ps

module tb_top
    import acs_pkg::*;
();

    localparam int CLK_PERIOD   = 4;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_WORDS = 1000;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PRINT_LIMIT  = 100;

    typedef struct packed {
        logic [QTY_W-1:0]   quantity;
        logic [VALUE_W-1:0] scaled_value;
        logic               divide_fault;
        logic [QTY_W-1:0]   next_channel;
    } scaled_word_t;

    typedef struct {
        logic [SAMPLE_W-1:0] adc_sample;
        bit                  wait_idle;
    } pending_word_t;

    logic clk;
    logic rst_n;

    acs_sample_if sample_ch ();
    acs_result_if result_ch ();

    analog_channel_scaler_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch)
    );

    pending_word_t pending_samples[$];
    scaled_word_t  expected_words[$];

    logic [QTY_W-1:0]    model_phase;
    logic [SAMPLE_W-1:0] model_saved_volt;

    int  error_count;
    int  cycle_count;
    bit  stim_go;
    bit  sample_taken;
    int  burst_left;
    int  gap_left;
    int  stall_mode;
    int  stall_left;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    task automatic report_mismatch(input string field, input int got, input int want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
        begin
            $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got,
                     want);
        end
    endtask

    // Scaling of one accepted sample; updates phase and saved voltage sample.
    task automatic predict_scaled(input logic [SAMPLE_W-1:0] x);
        scaled_word_t word;
        logic [31:0]  wide;
        logic [31:0]  quot;
        word = '0;
        case (model_phase)
            PHASE_CHIP:
            begin
                if (x < CHIP_LIMIT)
                begin
                    wide = (32'd28 * x) / 32'd75 - 32'd456;
                end
                else
                begin
                    wide = '0;
                end
                word.scaled_value = wide[VALUE_W-1:0];
                word.quantity     = PHASE_CHIP;
                word.next_channel = PHASE_VOLT;
            end
            PHASE_VOLT:
            begin
                wide = (32'd7 * x) / 32'd59;
                word.scaled_value = wide[VALUE_W-1:0];
                model_saved_volt  = x;
                word.quantity     = PHASE_VOLT;
                word.next_channel = PHASE_AIR;
            end
            PHASE_AIR:
            begin
                quot = '0;
                if (model_saved_volt != '0)
                begin
                    quot = (32'd91 * x) / {20'd0, model_saved_volt};
                end
                else
                begin
                    word.divide_fault = 1'b1;
                end
                wide = 32'd168 - {16'd0, quot[VALUE_W-1:0]};
                word.scaled_value = wide[VALUE_W-1:0];
                word.quantity     = PHASE_AIR;
                word.next_channel = PHASE_CHIP;
            end
            default:
            begin
                model_phase = PHASE_CHIP;
                return;
            end
        endcase
        model_phase = word.next_channel;
        expected_words.push_back(word);
    endtask

    task automatic add_sample(input logic [SAMPLE_W-1:0] x, input bit wait_idle);
        pending_word_t p;
        p.adc_sample = x;
        p.wait_idle  = wait_idle;
        pending_samples.push_back(p);
    endtask

    task automatic add_triple(input logic [SAMPLE_W-1:0] chip_x,
                              input logic [SAMPLE_W-1:0] volt_x,
                              input logic [SAMPLE_W-1:0] air_x, input bit wait_idle);
        add_sample(chip_x, wait_idle);
        add_sample(volt_x, 1'b0);
        add_sample(air_x, 1'b0);
    endtask

    // Sample side: accept detection and prediction at the rising edge.
    always @(posedge clk)
    begin
        sample_taken <= sample_ch.valid && sample_ch.ready;
        if (sample_ch.valid && sample_ch.ready)
        begin
            predict_scaled(sample_ch.adc_sample);
        end
    end

    // Result side: compare against the oldest expected word.
    always @(posedge clk)
    begin
        scaled_word_t want;
        if (result_ch.valid && result_ch.ready)
        begin
            if (expected_words.size() == 0)
            begin
                report_mismatch("unexpected result word", result_ch.scaled_value, 0);
            end
            else
            begin
                want = expected_words.pop_front();
                if (result_ch.quantity !== want.quantity)
                begin
                    report_mismatch("quantity", result_ch.quantity, want.quantity);
                end
                if (result_ch.scaled_value !== want.scaled_value)
                begin
                    report_mismatch("scaled_value", result_ch.scaled_value, want.scaled_value);
                end
                if (result_ch.divide_fault !== want.divide_fault)
                begin
                    report_mismatch("divide_fault", result_ch.divide_fault, want.divide_fault);
                end
                if (result_ch.next_channel !== want.next_channel)
                begin
                    report_mismatch("next_channel", result_ch.next_channel, want.next_channel);
                end
            end
        end
    end

    // Driver: bursts of words with random gaps; some words wait for an idle block.
    always @(negedge clk)
    begin
        if (stim_go && (!sample_ch.valid || sample_taken))
        begin
            if (sample_taken)
            begin
                void'(pending_samples.pop_front());
            end
            if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                sample_ch.valid <= 1'b0;
            end
            else if (pending_samples.size() == 0)
            begin
                sample_ch.valid <= 1'b0;
            end
            else if (pending_samples[0].wait_idle && expected_words.size() != 0)
            begin
                sample_ch.valid <= 1'b0;
            end
            else
            begin
                sample_ch.valid      <= 1'b1;
                sample_ch.adc_sample <= pending_samples[0].adc_sample;
                burst_left = burst_left - 1;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                end
            end
        end
    end

    // Receiver: stall pattern switching between always ready, random and long stalls.
    always @(negedge clk)
    begin
        if (stall_left <= 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 200);
        end
        stall_left = stall_left - 1;
        case (stall_mode)
            0:       result_ch.ready <= 1'b1;
            1:       result_ch.ready <= 1'($urandom_range(0, 1));
            default: result_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [SAMPLE_W-1:0] x;
        sample_ch.valid      = 1'b0;
        sample_ch.adc_sample = '0;
        result_ch.ready      = 1'b0;
        rst_n                = 1'b0;
        stim_go              = 1'b0;
        sample_taken         = 1'b0;
        error_count          = 0;
        cycle_count          = 0;
        burst_left           = 0;
        gap_left             = 0;
        stall_mode           = 0;
        stall_left           = 0;
        model_phase          = PHASE_CHIP;
        model_saved_volt     = '0;

        // zero divisor first, then field extremes, chip limit and wrap to negative
        add_triple(12'd0, 12'd0, 12'd4095, 1'b0);
        add_triple(12'd1999, 12'd4095, 12'd4095, 1'b0);
        add_triple(12'd2000, 12'd1, 12'd4095, 1'b0);
        add_triple(12'd4095, 12'd1, 12'd0, 1'b0);
        add_triple(12'd1, 12'd59, 12'd2048, 1'b0);
        add_triple(12'd1221, 12'd4094, 12'd1, 1'b0);
        add_triple(12'd1222, 12'd2048, 12'd2730, 1'b0);

        for (int k = 0; k < RANDOM_WORDS / 3; k++)
        begin
            case ($urandom_range(0, 3))
                0:       x = SAMPLE_W'($urandom_range(1900, 4095));
                default: x = SAMPLE_W'($urandom_range(0, 1999));
            endcase
            add_sample(x, (k % 80) == 0);
            case ($urandom_range(0, 15))
                0:       x = '0;
                1, 2:    x = SAMPLE_W'($urandom_range(1, 16));
                default: x = SAMPLE_W'($urandom());
            endcase
            add_sample(x, 1'b0);
            add_sample(SAMPLE_W'($urandom()), 1'b0);
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n   = 1'b1;
        stim_go = 1'b1;

        while (pending_samples.size() != 0 || sample_ch.valid)
        begin
            @(posedge clk);
        end
        while (expected_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_words.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
